// ===== src/chcs_pkg.sv =====
`timescale 1ns / 1ps
package chcs_pkg;

  localparam int COORD_W = 16;
  localparam int SUM_W   = 22;
  localparam int POINT_W = 3 * COORD_W;

  typedef struct packed {
    logic signed [COORD_W-1:0] cost;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

  typedef struct packed {
    logic take;
    logic done;
  } back_ctl_t;

endpackage

// ===== src/chcs_if.sv =====
`timescale 1ns / 1ps
interface chcs_pt_if;
  logic        valid;
  logic        ready;
  logic [15:0] pt_x;
  logic [15:0] pt_y;
  logic [15:0] pt_cost;
  logic        last_point;

  modport source (output valid, pt_x, pt_y, pt_cost, last_point, input ready);
  modport sink (input valid, pt_x, pt_y, pt_cost, last_point, output ready);
endinterface

interface chcs_hull_if;
  logic        valid;
  logic        ready;
  logic [15:0] hull_x;
  logic [15:0] hull_y;
  logic [15:0] hull_cost;
  logic [21:0] cost_sum;
  logic        overflow;
  logic        last_result;

  modport source (output valid, hull_x, hull_y, hull_cost, cost_sum, overflow, last_result,
                  input ready);
  modport sink (input valid, hull_x, hull_y, hull_cost, cost_sum, overflow, last_result,
                output ready);
endinterface

// ===== src/chcs_ram.sv =====
`timescale 1ns / 1ps
module chcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/chcs_front.sv =====
`timescale 1ns / 1ps
module chcs_front #(
  parameter int MAX_POINTS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  chcs_pt_if.sink                         pt,
  output logic                            st_we,
  output logic [$clog2(MAX_POINTS)-1:0]   st_waddr,
  output chcs_pkg::point_t                st_wdata,
  output logic                            job_valid,
  output logic [$clog2(MAX_POINTS+1)-1:0] job_count,
  output logic                            job_dropped,
  input  chcs_pkg::back_ctl_t             ctl
);
  import chcs_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_POINTS);

  logic [CW-1:0] count;
  logic          dropped;
  logic          pending;
  logic          accept;
  logic          room;

  assign pt.ready = !pending;
  assign accept   = pt.valid && pt.ready;
  assign room     = (count != FULL);

  assign st_we    = accept && room;
  assign st_waddr = count[AW-1:0];
  assign st_wdata = '{cost: pt.pt_cost, y: pt.pt_y, x: pt.pt_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      dropped     <= 1'b0;
      pending     <= 1'b0;
      job_valid   <= 1'b0;
      job_count   <= '0;
      job_dropped <= 1'b0;
    end else begin
      if (ctl.take) begin
        job_valid <= 1'b0;
      end
      if (ctl.done) begin
        pending <= 1'b0;
      end
      if (accept) begin
        if (pt.last_point) begin
          job_valid   <= 1'b1;
          pending     <= 1'b1;
          job_count   <= room ? count + CW'(1) : count;
          job_dropped <= dropped || !room;
          count       <= '0;
          dropped     <= 1'b0;
        end else if (room) begin
          count <= count + CW'(1);
        end else begin
          dropped <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== src/chcs_back.sv =====
`timescale 1ns / 1ps
module chcs_back #(
  parameter int MAX_POINTS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            job_valid,
  input  logic [$clog2(MAX_POINTS+1)-1:0] job_count,
  input  logic                            job_dropped,
  output chcs_pkg::back_ctl_t             ctl,
  output logic [$clog2(MAX_POINTS)-1:0]   st_raddr,
  input  chcs_pkg::point_t                st_rdata,
  chcs_hull_if.source                     hull
);
  import chcs_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [26:0] {
    ST_IDLE     = 27'h0000001,
    ST_ANC      = 27'h0000002,
    ST_SML      = 27'h0000004,
    ST_SRT_INIT = 27'h0000008,
    ST_SRT_I    = 27'h0000010,
    ST_SRT_P    = 27'h0000020,
    ST_SRT_O    = 27'h0000040,
    ST_SRT_Q    = 27'h0000080,
    ST_SRT_M    = 27'h0000100,
    ST_SRT_C    = 27'h0000200,
    ST_SRT_J    = 27'h0000400,
    ST_SC_I0    = 27'h0000800,
    ST_SC_I1    = 27'h0001000,
    ST_SC_I2    = 27'h0002000,
    ST_SC_C     = 27'h0004000,
    ST_SC_CR    = 27'h0008000,
    ST_SC_CP    = 27'h0010000,
    ST_SC_CHK   = 27'h0020000,
    ST_SC_A     = 27'h0040000,
    ST_SC_AP    = 27'h0080000,
    ST_SC_M     = 27'h0100000,
    ST_SC_X     = 27'h0200000,
    ST_SC_PUSH  = 27'h0400000,
    ST_EM_S     = 27'h0800000,
    ST_EM_P     = 27'h1000000,
    ST_EM_O     = 27'h2000000,
    ST_DONE     = 27'h4000000
  } state_t;

  state_t state, state_next;

  logic [CW-1:0] n, n_next;
  logic          drop, drop_next;
  logic [CW-1:0] i, i_next;
  logic [CW-1:0] j, j_next;
  logic [CW-1:0] m, m_next;
  logic [CW-1:0] d, d_next;
  logic [AW-1:0] anchor, anchor_next;
  logic [AW-1:0] p_addr, p_addr_next;
  logic [AW-1:0] o_addr, o_addr_next;
  logic [AW-1:0] s_addr, s_addr_next;
  logic [AW-1:0] cidx, cidx_next;
  logic signed [COORD_W-1:0] ax, ax_next, ay, ay_next;
  logic signed [COORD_W-1:0] tx, tx_next, ty, ty_next;
  logic signed [COORD_W-1:0] cx, cx_next, cy, cy_next;
  logic signed [COORD_W:0]   d1x, d1x_next, d1y, d1y_next;
  logic signed [COORD_W:0]   d2x, d2x_next, d2y, d2y_next;
  logic signed [2*COORD_W+1:0] pr1, pr2;
  logic signed [2*COORD_W+2:0] cr;
  logic [COORD_W+1:0] man1, man2;
  logic [COORD_W:0]   abs1x, abs1y, abs2x, abs2y;
  logic               m_less;
  logic signed [SUM_W-1:0] sum, sum_next;

  logic          o_we, s_we;
  logic [AW-1:0] o_waddr, s_waddr, o_wdata, s_wdata, o_rdata, s_rdata;

  logic out_free;
  logic emit;
  logic emit_last;

  chcs_ram #(.WIDTH(AW), .DEPTH(MAX_POINTS)) u_order (
    .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
    .raddr(o_addr_next), .rdata(o_rdata)
  );

  chcs_ram #(.WIDTH(AW), .DEPTH(MAX_POINTS)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_addr_next), .rdata(s_rdata)
  );

  assign st_raddr = p_addr_next;
  assign out_free = !hull.valid || hull.ready;
  assign cr       = (2*COORD_W+3)'(pr1) - (2*COORD_W+3)'(pr2);

  assign abs1x = d1x[COORD_W] ? (COORD_W+1)'(-d1x) : d1x;
  assign abs1y = d1y[COORD_W] ? (COORD_W+1)'(-d1y) : d1y;
  assign abs2x = d2x[COORD_W] ? (COORD_W+1)'(-d2x) : d2x;
  assign abs2y = d2y[COORD_W] ? (COORD_W+1)'(-d2y) : d2y;
  assign man1  = (COORD_W+2)'(abs1x) + (COORD_W+2)'(abs1y);
  assign man2  = (COORD_W+2)'(abs2x) + (COORD_W+2)'(abs2y);

  always_ff @(posedge clk) begin
    pr1    <= d1x * d2y;
    pr2    <= d1y * d2x;
    m_less <= man1 < man2;
  end

  always_comb begin
    state_next  = state;
    n_next      = n;
    drop_next   = drop;
    i_next      = i;
    j_next      = j;
    m_next      = m;
    d_next      = d;
    anchor_next = anchor;
    p_addr_next = p_addr;
    o_addr_next = o_addr;
    s_addr_next = s_addr;
    cidx_next   = cidx;
    ax_next     = ax;
    ay_next     = ay;
    tx_next     = tx;
    ty_next     = ty;
    cx_next     = cx;
    cy_next     = cy;
    d1x_next    = d1x;
    d1y_next    = d1y;
    d2x_next    = d2x;
    d2y_next    = d2y;
    sum_next    = sum;
    o_we        = 1'b0;
    o_waddr     = j[AW-1:0];
    o_wdata     = i[AW-1:0];
    s_we        = 1'b0;
    s_waddr     = d[AW-1:0];
    s_wdata     = cidx;
    ctl         = '0;
    emit        = 1'b0;
    emit_last   = 1'b0;

    case (state)
      ST_IDLE: begin
        if (job_valid) begin
          ctl.take    = 1'b1;
          n_next      = job_count;
          drop_next   = job_dropped;
          i_next      = '0;
          p_addr_next = '0;
          sum_next    = '0;
          if (job_count == '0) begin
            state_next = ST_DONE;
          end else if (job_count < CW'(3)) begin
            state_next = ST_SML;
          end else begin
            state_next = ST_ANC;
          end
        end
      end
      ST_SML: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_last = (i + CW'(1) == n);
          sum_next  = sum + SUM_W'(st_rdata.cost);
          if (emit_last) begin
            state_next = ST_DONE;
          end else begin
            i_next      = i + CW'(1);
            p_addr_next = AW'(i + CW'(1));
          end
        end
      end
      ST_ANC: begin
        if (i == '0 || st_rdata.y < ay || (st_rdata.y == ay && st_rdata.x < ax)) begin
          ax_next     = st_rdata.x;
          ay_next     = st_rdata.y;
          anchor_next = i[AW-1:0];
        end
        if (i + CW'(1) == n) begin
          state_next = ST_SRT_INIT;
        end else begin
          i_next      = i + CW'(1);
          p_addr_next = AW'(i + CW'(1));
        end
      end
      ST_SRT_INIT: begin
        o_we       = 1'b1;
        o_waddr    = '0;
        o_wdata    = anchor;
        m_next     = CW'(1);
        i_next     = '0;
        state_next = ST_SRT_I;
      end
      ST_SRT_I: begin
        if (i == n) begin
          o_addr_next = '0;
          state_next  = ST_SC_I0;
        end else if (i[AW-1:0] == anchor) begin
          i_next = i + CW'(1);
        end else begin
          p_addr_next = i[AW-1:0];
          state_next  = ST_SRT_P;
        end
      end
      ST_SRT_P: begin
        d1x_next = (COORD_W+1)'(st_rdata.x) - (COORD_W+1)'(ax);
        d1y_next = (COORD_W+1)'(st_rdata.y) - (COORD_W+1)'(ay);
        j_next   = m;
        if (m > CW'(1)) begin
          o_addr_next = AW'(m - CW'(1));
          state_next  = ST_SRT_O;
        end else begin
          o_we       = 1'b1;
          o_waddr    = m[AW-1:0];
          m_next     = m + CW'(1);
          i_next     = i + CW'(1);
          state_next = ST_SRT_I;
        end
      end
      ST_SRT_O: begin
        p_addr_next = o_rdata;
        state_next  = ST_SRT_Q;
      end
      ST_SRT_Q: begin
        d2x_next   = (COORD_W+1)'(st_rdata.x) - (COORD_W+1)'(ax);
        d2y_next   = (COORD_W+1)'(st_rdata.y) - (COORD_W+1)'(ay);
        state_next = ST_SRT_M;
      end
      ST_SRT_M: begin
        state_next = ST_SRT_C;
      end
      ST_SRT_C: begin
        o_we = 1'b1;
        if (cr > 0 || (cr == 0 && m_less)) begin
          o_wdata    = o_rdata;
          j_next     = j - CW'(1);
          state_next = ST_SRT_J;
        end else begin
          m_next     = m + CW'(1);
          i_next     = i + CW'(1);
          state_next = ST_SRT_I;
        end
      end
      ST_SRT_J: begin
        if (j > CW'(1)) begin
          o_addr_next = AW'(j - CW'(1));
          state_next  = ST_SRT_O;
        end else begin
          o_we       = 1'b1;
          m_next     = m + CW'(1);
          i_next     = i + CW'(1);
          state_next = ST_SRT_I;
        end
      end
      ST_SC_I0: begin
        s_we        = 1'b1;
        s_waddr     = '0;
        s_wdata     = o_rdata;
        o_addr_next = AW'(1);
        state_next  = ST_SC_I1;
      end
      ST_SC_I1: begin
        s_we        = 1'b1;
        s_waddr     = AW'(1);
        s_wdata     = o_rdata;
        p_addr_next = o_rdata;
        state_next  = ST_SC_I2;
      end
      ST_SC_I2: begin
        tx_next    = st_rdata.x;
        ty_next    = st_rdata.y;
        d_next     = CW'(2);
        i_next     = CW'(2);
        state_next = ST_SC_C;
      end
      ST_SC_C: begin
        o_addr_next = i[AW-1:0];
        state_next  = ST_SC_CR;
      end
      ST_SC_CR: begin
        cidx_next   = o_rdata;
        p_addr_next = o_rdata;
        state_next  = ST_SC_CP;
      end
      ST_SC_CP: begin
        cx_next    = st_rdata.x;
        cy_next    = st_rdata.y;
        state_next = ST_SC_CHK;
      end
      ST_SC_CHK: begin
        if (d >= CW'(2)) begin
          s_addr_next = AW'(d - CW'(2));
          state_next  = ST_SC_A;
        end else begin
          state_next = ST_SC_PUSH;
        end
      end
      ST_SC_A: begin
        p_addr_next = s_rdata;
        state_next  = ST_SC_AP;
      end
      ST_SC_AP: begin
        d1x_next   = (COORD_W+1)'(tx) - (COORD_W+1)'(st_rdata.x);
        d1y_next   = (COORD_W+1)'(ty) - (COORD_W+1)'(st_rdata.y);
        d2x_next   = (COORD_W+1)'(cx) - (COORD_W+1)'(st_rdata.x);
        d2y_next   = (COORD_W+1)'(cy) - (COORD_W+1)'(st_rdata.y);
        state_next = ST_SC_M;
      end
      ST_SC_M: begin
        state_next = ST_SC_X;
      end
      ST_SC_X: begin
        if (cr <= 0) begin
          tx_next    = st_rdata.x;
          ty_next    = st_rdata.y;
          d_next     = d - CW'(1);
          state_next = ST_SC_CHK;
        end else begin
          state_next = ST_SC_PUSH;
        end
      end
      ST_SC_PUSH: begin
        s_we    = 1'b1;
        tx_next = cx;
        ty_next = cy;
        d_next  = d + CW'(1);
        i_next  = i + CW'(1);
        if (i + CW'(1) == n) begin
          j_next     = d;
          state_next = ST_EM_S;
        end else begin
          state_next = ST_SC_C;
        end
      end
      ST_EM_S: begin
        s_addr_next = j[AW-1:0];
        state_next  = ST_EM_P;
      end
      ST_EM_P: begin
        p_addr_next = s_rdata;
        state_next  = ST_EM_O;
      end
      ST_EM_O: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_last = (j == '0);
          sum_next  = sum + SUM_W'(st_rdata.cost);
          if (emit_last) begin
            state_next = ST_DONE;
          end else begin
            j_next     = j - CW'(1);
            state_next = ST_EM_S;
          end
        end
      end
      ST_DONE: begin
        ctl.done   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      hull.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        hull.valid <= 1'b1;
      end else if (hull.ready) begin
        hull.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    n      <= n_next;
    drop   <= drop_next;
    i      <= i_next;
    j      <= j_next;
    m      <= m_next;
    d      <= d_next;
    anchor <= anchor_next;
    p_addr <= p_addr_next;
    o_addr <= o_addr_next;
    s_addr <= s_addr_next;
    cidx   <= cidx_next;
    ax     <= ax_next;
    ay     <= ay_next;
    tx     <= tx_next;
    ty     <= ty_next;
    cx     <= cx_next;
    cy     <= cy_next;
    d1x    <= d1x_next;
    d1y    <= d1y_next;
    d2x    <= d2x_next;
    d2y    <= d2y_next;
    sum    <= sum_next;
    if (emit) begin
      hull.hull_x      <= st_rdata.x;
      hull.hull_y      <= st_rdata.y;
      hull.hull_cost   <= st_rdata.cost;
      hull.cost_sum    <= sum_next;
      hull.overflow    <= drop;
      hull.last_result <= emit_last;
    end
  end
endmodule

// ===== src/convex_hull_cost_sum.sv =====
`timescale 1ns / 1ps
// input: points load at one per cycle except while a hull pass is pending
// pass: the last point starts a pass over n stored points: anchor search, insertion sort by
// polar angle with shifting compares, a scan with stack tests per point, and vertex emission
// flow: input stalls after the last point until the final vertex enters the output register
// reset: synchronous rst clears point count, drop flag, job queue, sequencer and output valid
module convex_hull_cost_sum #(
  parameter int MAX_POINTS = 64
) (
  input  logic          clk,
  input  logic          rst,
  chcs_pt_if.sink       pt,
  chcs_hull_if.source   hull
);
  import chcs_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  logic          st_we;
  logic [AW-1:0] st_waddr;
  logic [AW-1:0] st_raddr;
  point_t        st_wdata;
  point_t        st_rdata;
  logic          job_valid;
  logic [CW-1:0] job_count;
  logic          job_dropped;
  back_ctl_t     ctl;

  chcs_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk(clk), .rst(rst), .pt(pt),
    .st_we(st_we), .st_waddr(st_waddr), .st_wdata(st_wdata),
    .job_valid(job_valid), .job_count(job_count), .job_dropped(job_dropped),
    .ctl(ctl)
  );

  chcs_ram #(.WIDTH(POINT_W), .DEPTH(MAX_POINTS)) u_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  chcs_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk(clk), .rst(rst),
    .job_valid(job_valid), .job_count(job_count), .job_dropped(job_dropped),
    .ctl(ctl), .st_raddr(st_raddr), .st_rdata(st_rdata), .hull(hull)
  );
endmodule

// ===== tb/convex_hull_cost_sum_test.sv =====
`timescale 1ns / 1ps
module convex_hull_cost_sum_test;
  import chcs_pkg::*;

  localparam int MAXP = 64;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] c;
    logic        last;
  } request_t;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] c;
    logic [21:0] sum;
    logic        ovf;
    logic        last;
  } vertex_t;

  logic clk = 0;
  logic rst = 1;

  chcs_pt_if   pt();
  chcs_hull_if hull();

  convex_hull_cost_sum #(.MAX_POINTS(MAXP)) dut (.clk(clk), .rst(rst), .pt(pt), .hull(hull));

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  request_t pending[$];
  vertex_t  hull_expected[$];
  int       errors = 0;
  int       hold_cycles = 0;

  // hull predictor state
  point_t   set_pts[MAXP];
  int       set_count = 0;
  bit       set_dropped = 0;

  function automatic longint sx(logic [15:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint turn(int a, int b, int c);
    longint ax, ay;
    ax = sx(set_pts[a].x);
    ay = sx(set_pts[a].y);
    return (sx(set_pts[b].x) - ax) * (sx(set_pts[c].y) - ay)
         - (sx(set_pts[b].y) - ay) * (sx(set_pts[c].x) - ax);
  endfunction

  function automatic longint dist_sq(int a, int b);
    longint dx, dy;
    dx = sx(set_pts[a].x) - sx(set_pts[b].x);
    dy = sx(set_pts[a].y) - sx(set_pts[b].y);
    return dx * dx + dy * dy;
  endfunction

  function automatic bit angle_less(int anc, int p, int q);
    longint cr;
    cr = turn(anc, p, q);
    if (cr != 0) return cr > 0;
    return dist_sq(anc, p) < dist_sq(anc, q);
  endfunction

  function automatic void push_vertex(int idx, ref longint sum, input bit last);
    vertex_t v;
    sum += sx(set_pts[idx].cost);
    v.x = set_pts[idx].x;
    v.y = set_pts[idx].y;
    v.c = set_pts[idx].cost;
    v.sum = sum[21:0];
    v.ovf = set_dropped;
    v.last = last;
    hull_expected.insert(hull_expected.size(), v);
  endfunction

  function automatic void predict_hull(request_t r);
    int order[MAXP];
    int stk[MAXP];
    int n, anc, m, j, depth, p, c;
    longint sum;
    sum = 0;
    if (set_count < MAXP) begin
      set_pts[set_count] = '{cost: r.c, y: r.y, x: r.x};
      set_count++;
    end else begin
      set_dropped = 1;
    end
    if (!r.last) return;
    n = set_count;
    if (n < 3) begin
      for (int i = 0; i < n; i++) push_vertex(i, sum, i + 1 == n);
    end else begin
      anc = 0;
      for (int i = 1; i < n; i++)
        if (sx(set_pts[i].y) < sx(set_pts[anc].y) ||
            (set_pts[i].y == set_pts[anc].y && sx(set_pts[i].x) < sx(set_pts[anc].x)))
          anc = i;
      order[0] = anc;
      m = 1;
      for (int i = 0; i < n; i++) begin
        if (i == anc) continue;
        j = m;
        while (j > 1 && angle_less(anc, i, order[j-1])) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = i;
        m++;
      end
      stk[0] = order[0];
      stk[1] = order[1];
      depth = 2;
      for (int i = 2; i < n; i++) begin
        c = order[i];
        depth--;
        p = stk[depth];
        while (depth > 0 && turn(stk[depth-1], p, c) <= 0) begin
          depth--;
          p = stk[depth];
        end
        stk[depth++] = p;
        stk[depth++] = c;
      end
      for (int k = depth; k > 0; k--) push_vertex(stk[k-1], sum, k == 1);
    end
    set_count = 0;
    set_dropped = 0;
  endfunction

  // stimulus builders
  function automatic logic [15:0] rnd_coord(int mode);
    case (mode)
      0: return 16'($urandom_range(0, 20)) - 16'd10;
      1: return 16'($urandom_range(0, 400)) - 16'd200;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void add_point(logic [15:0] x, logic [15:0] y, logic [15:0] c, bit last);
    request_t r;
    r.x = x;
    r.y = y;
    r.c = c;
    r.last = last;
    pending.insert(pending.size(), r);
  endfunction

  function automatic void add_random_set(int n, int mode);
    for (int i = 0; i < n; i++)
      add_point(rnd_coord(mode), rnd_coord(mode), 16'($urandom), i == n - 1);
  endfunction

  // input acceptance seen at the rising edge
  bit in_taken = 0;
  always @(posedge clk) begin
    in_taken = 0;
    if (!rst && pt.valid && pt.ready) begin
      predict_hull(pending.pop_front());
      in_taken = 1;
    end
  end

  // driver: bursts and gaps, changes on falling edge
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      pt.valid <= 0;
    end else if (!pt.valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        pt.valid <= 0;
      end else if (pending.size() > 0) begin
        pt.valid <= 1;
        pt.pt_x <= pending[0].x;
        pt.pt_y <= pending[0].y;
        pt.pt_cost <= pending[0].c;
        pt.last_point <= pending[0].last;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
        end
      end else begin
        pt.valid <= 0;
      end
    end
  end

  initial begin
    pt.valid = 0;
    pt.pt_x = 0;
    pt.pt_y = 0;
    pt.pt_cost = 0;
    pt.last_point = 0;
    hull.ready = 0;
  end

  // receiver stall pattern plus a long hold-off
  int stall_phase = 0;
  always @(negedge clk) begin
    if (rst) begin
      hull.ready <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      hull.ready <= 0;
    end else begin
      stall_phase = (stall_phase + 1) % 97;
      if (stall_phase < 30) hull.ready <= 1;
      else hull.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    vertex_t e;
    if (!rst && hull.valid && hull.ready) begin
      if (hull_expected.size() == 0) begin
        $error("unexpected hull vertex x=%h y=%h", hull.hull_x, hull.hull_y);
        errors++;
      end else begin
        e = hull_expected.pop_front();
        if (hull.hull_x !== e.x) begin
          $error("hull_x expected %h got %h", e.x, hull.hull_x); errors++;
        end
        if (hull.hull_y !== e.y) begin
          $error("hull_y expected %h got %h", e.y, hull.hull_y); errors++;
        end
        if (hull.hull_cost !== e.c) begin
          $error("hull_cost expected %h got %h", e.c, hull.hull_cost); errors++;
        end
        if (hull.cost_sum !== e.sum) begin
          $error("cost_sum expected %h got %h", e.sum, hull.cost_sum); errors++;
        end
        if (hull.overflow !== e.ovf) begin
          $error("overflow expected %b got %b", e.ovf, hull.overflow); errors++;
        end
        if (hull.last_result !== e.last) begin
          $error("last_result expected %b got %b", e.last, hull.last_result); errors++;
        end
      end
    end
  end

  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    // directed: single, pair, extremes, collinear, duplicates
    add_point(16'h7fff, 16'h8000, 16'h7fff, 1);
    add_point(16'h8000, 16'h7fff, 16'h8000, 0);
    add_point(16'h7fff, 16'h7fff, 16'hffff, 1);
    add_point(16'h8000, 16'h8000, 16'h8000, 0);
    add_point(16'h7fff, 16'h8000, 16'h8000, 0);
    add_point(16'h7fff, 16'h7fff, 16'h8000, 0);
    add_point(16'h8000, 16'h7fff, 16'h8000, 0);
    add_point(16'h0000, 16'h0000, 16'h7fff, 1);
    add_point(0, 0, 1, 0);
    add_point(2, 2, 2, 0);
    add_point(1, 1, 3, 0);
    add_point(0, 0, 4, 0);
    add_point(3, 0, 5, 0);
    add_point(3, 3, 6, 0);
    add_point(0, 3, 7, 1);
    add_point(5, 5, 1, 0);
    add_point(5, 5, 2, 0);
    add_point(5, 5, 3, 1);
    repeat (6) @(posedge clk);
    rst <= 0;
    // overflow: 66 points, last one dropped too
    add_random_set(MAXP + 2, 0);
    while (pending.size() > 0 || hull_expected.size() > 0) @(posedge clk);
    // long receiver hold while sets stream in
    add_random_set(10, 0);
    add_random_set(4, 2);
    add_random_set(6, 1);
    hold_cycles = 3000;
    while (pending.size() < 3 + 20 && pending.size() > 0) @(posedge clk);
    for (int s = 0; s < 5; s++) begin
      int n, md;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
      md = $urandom_range(0, 2);
      add_random_set(n, md);
      while (pending.size() > 16) @(posedge clk);
    end
    while (pending.size() > 0) @(posedge clk);
    while (hull_expected.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
